[sv/array_list_insert_remove_core_assert.svh]
// Assertion macros for the array list core.
`ifndef ARRAY_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define ARRAY_LIST_INSERT_REMOVE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ALIC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("alic assertion failed");
`define ALIC_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("alic reset assertion failed");
`else
`define ALIC_ASSERT(label, prop)
`define ALIC_ASSERT_RST(label, prop)
`endif

`endif

[sv/alic_pkg.sv]
// Package with types and constants of the array list core.
`default_nettype none

package alic_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int ENTRY_W  = 5;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_REM_HEAD = 3'd3,
        OP_REM_TAIL = 3'd4,
        OP_REM_POS  = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } t_cell_op;

endpackage

`default_nettype wire

[sv/alic_in_if.sv]
// Input channel of the array list core: one list operation per word.
`default_nettype none

interface alic_in_if import alic_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] payload;

    modport source (output valid, output op, output position, output payload, input ready);
    modport sink   (input valid, input op, input position, input payload, output ready);
endinterface

`default_nettype wire

[sv/alic_out_if.sv]
// Output channel of the array list core: one result per word.
`default_nettype none

interface alic_out_if import alic_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  removed_value;
    logic [ENTRY_W-1:0] entry_count;

    modport source (output valid, output status, output removed_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input entry_count,
                    output ready);
endinterface

`default_nettype wire

[sv/alic_cell.sv]
// One storage cell of the list: holds one entry, loads, or takes a neighbor's entry.
`default_nettype none

module alic_cell import alic_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_cell_op          i_op,
    input  wire logic [DATA_W-1:0] i_payload,
    input  wire logic [DATA_W-1:0] i_left,
    input  wire logic [DATA_W-1:0] i_right,
    output      logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        case (i_op)
            CELL_LOAD:  n_data = i_payload;
            CELL_LEFT:  n_data = i_left;
            CELL_RIGHT: n_data = i_right;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[sv/array_list_insert_remove_core.sv]
// Top level of the array list core: control, row of cells and result register.
`default_nettype none

// Ordered list of up to CAPACITY 32-bit words held in a row of cells, packed from
// cell 0 upward, with an element count. Each input word inserts at the head, the
// tail or a 1-based position, or removes from the head, the tail or a 1-based
// position; every cell shifts toward or away from its neighbor in the same clock,
// so the block takes one operation per cycle while its output register is empty
// or being read, and presents its result in the cycle after acceptance through
// an output register. Status is ok, full, empty or bad position; removed_value
// is zero unless a remove succeeds. Op codes 6 and 7 leave the list unchanged
// and report ok with the current count. No clearing pass is needed after reset.

`include "array_list_insert_remove_core_assert.svh"

module array_list_insert_remove_core import alic_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    alic_in_if.sink   i_in,
    alic_out_if.source o_out
);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_out_status;
    logic [DATA_W-1:0]  r_out_removed;
    logic [ENTRY_W-1:0] r_out_count;

    logic               w_accept;
    logic               w_do_ins;
    logic               w_do_rem;
    t_status            w_status;
    logic [CMP_W-1:0]   w_slot;
    logic [CMP_W-1:0]   w_cnt_x;
    logic [CMP_W-1:0]   w_pos_x;
    logic               w_full;
    logic               w_empty;
    logic [DATA_W-1:0]  w_removed;
    t_cell_op           w_cell_op   [CAPACITY];
    logic [DATA_W-1:0]  w_cell_data [CAPACITY];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_cnt_x = CMP_W'(r_count);
    assign w_pos_x = CMP_W'(i_in.position);
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_status = ST_OK;
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        w_slot   = '0;
        case (i_in.op)
            OP_INS_HEAD: begin
                if (w_full) w_status = ST_FULL;
                else        w_do_ins = 1'b1;
            end
            OP_INS_TAIL: begin
                w_slot = w_cnt_x;
                if (w_full) w_status = ST_FULL;
                else        w_do_ins = 1'b1;
            end
            OP_INS_POS: begin
                w_slot = w_pos_x - 1'b1;
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_x == '0 || w_pos_x > w_cnt_x + 1'b1) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_do_ins = 1'b1;
                end
            end
            OP_REM_HEAD: begin
                if (w_empty) w_status = ST_EMPTY;
                else         w_do_rem = 1'b1;
            end
            OP_REM_TAIL: begin
                w_slot = w_cnt_x - 1'b1;
                if (w_empty) w_status = ST_EMPTY;
                else         w_do_rem = 1'b1;
            end
            OP_REM_POS: begin
                w_slot = w_pos_x - 1'b1;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                    w_status = ST_BADPOS;
                end else begin
                    w_do_rem = 1'b1;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        w_removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_cell_op[k] = CELL_HOLD;
            if (w_accept && w_do_ins) begin
                if (CMP_W'(k) == w_slot) begin
                    w_cell_op[k] = CELL_LOAD;
                end else if (CMP_W'(k) > w_slot && CMP_W'(k) <= w_cnt_x) begin
                    w_cell_op[k] = CELL_LEFT;
                end
            end else if (w_accept && w_do_rem) begin
                if (CMP_W'(k) >= w_slot && CMP_W'(k) + 1'b1 < w_cnt_x) begin
                    w_cell_op[k] = CELL_RIGHT;
                end
            end
            if (w_do_rem && CMP_W'(k) == w_slot) begin
                w_removed = w_removed | w_cell_data[k];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_W-1:0] w_left;
            logic [DATA_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell_data[g+1];
            end
            alic_cell u_cell (
                .i_clk     (i_clk),
                .i_op      (w_cell_op[g]),
                .i_payload (i_in.payload),
                .i_left    (w_left),
                .i_right   (w_right),
                .o_data    (w_cell_data[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_do_ins)      n_count = r_count + 1'b1;
        else if (w_do_rem) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status  <= w_status;
            r_out_removed <= w_removed;
            r_out_count   <= ENTRY_W'(n_count);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.removed_value = r_out_removed;
    assign o_out.entry_count   = r_out_count;

    `ALIC_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY))
    `ALIC_ASSERT(a_out_count_match, r_out_valid |-> r_out_count == ENTRY_W'(r_count))
    `ALIC_ASSERT(a_ins_grows, w_accept && w_do_ins |=> r_count == $past(r_count) + 1'b1)
    `ALIC_ASSERT(a_err_holds, w_accept && w_status != ST_OK |=> r_count == $past(r_count))
    `ALIC_ASSERT_RST(a_reset_clear, !i_rst_n |=> r_count == '0 && !r_out_valid)

endmodule

`default_nettype wire
